>>> rtl/core/tpbs_pkg.sv
`timescale 1ns / 1ps

package tpbs_pkg;

    // Store geometry
    localparam int BANKS            = 2;
    localparam int PATCHES_PER_BANK = 16;
    localparam int RAW_BYTES        = 32;
    localparam int DATA_BYTES       = RAW_BYTES - 1;
    localparam int STORE_SIZE       = BANKS * PATCHES_PER_BANK * DATA_BYTES;

    localparam int ADDR_W = (STORE_SIZE > 1) ? $clog2(STORE_SIZE) : 1;
    localparam int BANK_W = (BANKS > 1) ? $clog2(BANKS) : 1;
    localparam int SLOT_W = (PATCHES_PER_BANK > 1) ? $clog2(PATCHES_PER_BANK) : 1;
    localparam int BYTE_W = $clog2(RAW_BYTES);

    // Serial frame: start bit, 8 data bits, two stop bits
    localparam int FRAME_BITS = 11;
    localparam int FBIT_W     = 4;

    // Tone lengths
    localparam int PILOT_W = 16;
    localparam int SEP_W   = 10;
    localparam logic [PILOT_W-1:0] PILOT_RESET = 16'd4096;
    localparam logic [SEP_W-1:0]   SEP_RESET   = 10'd48;

    // Register indexes
    localparam logic REG_PILOT = 1'b0;
    localparam logic REG_SEP   = 1'b1;

    // Command queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Operation codes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // Input word
    typedef struct packed {
        logic       op;
        logic       bank;
        logic [3:0] slot;
        logic [4:0] byte_index;
        logic [7:0] data;
    } t_in_word;

    // Result word
    typedef struct packed {
        logic line_bit;
        logic bit_valid;
        logic last;
    } t_out_word;

    // Classified command passed from front to back
    typedef struct packed {
        logic              is_load;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [7:0]        wr_data;
    } t_cmd;

endpackage

>>> rtl/core/tape_patch_bit_serializer_unit.sv
`timescale 1ns / 1ps
// Channel   Direction  Word        Handshake
// ---------------------------------------------------------------
// input     in         t_in_word   i_in_valid / o_in_ready
// result    out        t_out_word  o_out_valid / i_out_ready
// config    in         APB regs    psel, penable, pwrite, pready
//
// One word per cycle while neither side stalls: a tick reads a byte
// prefetched from the patch store the cycle before. After a load the next
// tick waits while the store byte for the restarted position is read again.
// Reset is synchronous, active low; the patch store holds no reset value.
// A two-entry queue between classifier and sequencer lets input and result
// sides stall on their own; the result register accepts a word while the
// previous one is being taken.

module tape_patch_bit_serializer_unit
    import tpbs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_word    i_in_word,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_word   o_out_word,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [PILOT_W-1:0] r_pilot_bits;
    logic [SEP_W-1:0]   r_separator_bits;
    logic               q_valid;
    logic               q_pop;
    t_cmd               q_cmd;
    logic               cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    // Hold configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pilot_bits     <= PILOT_RESET;
            r_separator_bits <= SEP_RESET;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_PILOT) begin
                r_pilot_bits <= pwdata[PILOT_W-1:0];
            end else begin
                r_separator_bits <= pwdata[SEP_W-1:0];
            end
        end
    end

    // Return register contents
    always_comb begin
        case (paddr[2])
            REG_PILOT: prdata = 32'(r_pilot_bits);
            REG_SEP:   prdata = 32'(r_separator_bits);
            default:   prdata = '0;
        endcase
    end

    tpbs_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_word  (i_in_word),
        .o_q_valid  (q_valid),
        .o_q_cmd    (q_cmd),
        .i_q_pop    (q_pop)
    );

    tpbs_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_q_valid        (q_valid),
        .i_q_cmd          (q_cmd),
        .o_q_pop          (q_pop),
        .i_pilot_bits     (r_pilot_bits),
        .i_separator_bits (r_separator_bits),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_out_word       (o_out_word)
    );

endmodule

>>> rtl/core/tpbs_front.sv
`timescale 1ns / 1ps

module tpbs_front
    import tpbs_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_in_word i_in_word,
    output logic     o_q_valid,
    output t_cmd     o_q_cmd,
    input  logic     i_q_pop
);

    t_cmd              r_q [QDEPTH];
    logic [QPTR_W-1:0] r_wp;
    logic [QPTR_W-1:0] r_rp;
    logic [QCNT_W-1:0] r_cnt;
    t_cmd              n_cmd;
    logic              push;
    logic              in_range;

    // Classify the incoming word and compute its store address
    always_comb begin
        in_range = (int'(i_in_word.bank) < BANKS)
                && (int'(i_in_word.slot) < PATCHES_PER_BANK)
                && (int'(i_in_word.byte_index) < DATA_BYTES);
        n_cmd.is_load = (i_in_word.op == OP_LOAD);
        n_cmd.wr_en   = (i_in_word.op == OP_LOAD) && in_range;
        n_cmd.wr_addr = ADDR_W'((int'(i_in_word.bank) * PATCHES_PER_BANK
                        + int'(i_in_word.slot)) * DATA_BYTES
                        + int'(i_in_word.byte_index));
        n_cmd.wr_data = i_in_word.data;
    end

    assign o_in_ready = (r_cnt != QCNT_W'(QDEPTH));
    assign push       = i_in_valid && o_in_ready;
    assign o_q_valid  = (r_cnt != '0);
    assign o_q_cmd    = r_q[r_rp];

    // Hold queued commands
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= n_cmd;
        end
    end

    // Advance queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= (r_wp == QPTR_W'(QDEPTH - 1)) ? '0 : r_wp + QPTR_W'(1);
            end
            if (i_q_pop) begin
                r_rp <= (r_rp == QPTR_W'(QDEPTH - 1)) ? '0 : r_rp + QPTR_W'(1);
            end
            r_cnt <= r_cnt + QCNT_W'(push) - QCNT_W'(i_q_pop);
        end
    end

endmodule

>>> rtl/core/tpbs_back.sv
`timescale 1ns / 1ps

module tpbs_back
    import tpbs_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    input  t_cmd               i_q_cmd,
    output logic               o_q_pop,
    input  logic [PILOT_W-1:0] i_pilot_bits,
    input  logic [SEP_W-1:0]   i_separator_bits,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output t_out_word          o_out_word
);

    typedef enum logic [1:0] {
        PH_PILOT,
        PH_DATA,
        PH_SEP
    } t_phase;

    logic [7:0]        r_store [STORE_SIZE];
    logic [7:0]        r_rd_data;
    logic              r_rd_ok;

    t_phase            r_phase,  n_phase;
    logic [PILOT_W-1:0] r_tone,  n_tone;
    logic [BANK_W-1:0] r_bank,   n_bank;
    logic [SLOT_W-1:0] r_slot,   n_slot;
    logic              r_copy,   n_copy;
    logic [BYTE_W-1:0] r_byte,   n_byte;
    logic [FBIT_W-1:0] r_fbit,   n_fbit;
    logic [7:0]        r_sum,    n_sum;
    logic              r_done,   n_done;
    logic              r_ov;
    t_out_word         r_out,    n_out;

    logic              fire;
    logic [7:0]        cur_byte;
    logic [PILOT_W:0]  tone_inc;
    logic [PILOT_W:0]  pilot_lim;
    logic [PILOT_W:0]  sep_lim;
    logic [BYTE_W-1:0] rd_off;
    logic [ADDR_W-1:0] rd_addr;

    // Take a command when the result slot frees and, for a tick, store data is current
    assign fire    = i_q_valid && (!r_ov || i_out_ready) && (i_q_cmd.is_load || r_rd_ok);
    assign o_q_pop = fire;

    assign cur_byte  = (int'(r_byte) >= DATA_BYTES) ? r_sum : r_rd_data;
    assign tone_inc  = {1'b0, r_tone} + (PILOT_W+1)'(1);
    assign pilot_lim = (i_pilot_bits == '0) ? (PILOT_W+1)'(1)
                                            : {1'b0, i_pilot_bits};
    assign sep_lim   = (i_separator_bits == '0) ? (PILOT_W+1)'(1)
                                                : (PILOT_W+1)'(i_separator_bits);

    // Sequence the frame and tone counters
    always_comb begin
        n_phase = r_phase;
        n_tone  = r_tone;
        n_bank  = r_bank;
        n_slot  = r_slot;
        n_copy  = r_copy;
        n_byte  = r_byte;
        n_fbit  = r_fbit;
        n_sum   = r_sum;
        n_done  = r_done;
        n_out.line_bit  = 1'b1;
        n_out.bit_valid = 1'b0;
        n_out.last      = 1'b0;
        if (fire) begin
            if (i_q_cmd.is_load) begin
                n_phase = PH_PILOT;
                n_tone  = '0;
                n_bank  = '0;
                n_slot  = '0;
                n_copy  = 1'b0;
                n_byte  = '0;
                n_fbit  = '0;
                n_sum   = '0;
                n_done  = 1'b0;
            end else if (!r_done) begin
                n_out.bit_valid = 1'b1;
                case (r_phase)
                    PH_DATA: begin
                        if (r_fbit == '0) begin
                            n_out.line_bit = 1'b0;
                        end else if (r_fbit <= FBIT_W'(8)) begin
                            n_out.line_bit = cur_byte[3'(r_fbit - FBIT_W'(1))];
                        end else begin
                            n_out.line_bit = 1'b1;
                        end
                        if (r_fbit == FBIT_W'(FRAME_BITS - 1)) begin
                            n_fbit = '0;
                            if (int'(r_byte) < DATA_BYTES) begin
                                n_sum = r_sum + cur_byte;
                            end
                            if (r_byte == BYTE_W'(RAW_BYTES - 1)) begin
                                n_byte  = '0;
                                n_phase = PH_SEP;
                                n_tone  = '0;
                            end else begin
                                n_byte = r_byte + BYTE_W'(1);
                            end
                        end else begin
                            n_fbit = r_fbit + FBIT_W'(1);
                        end
                    end
                    PH_SEP: begin
                        n_tone = tone_inc[PILOT_W-1:0];
                        if (tone_inc >= sep_lim) begin
                            n_tone  = '0;
                            n_sum   = '0;
                            n_byte  = '0;
                            n_fbit  = '0;
                            n_phase = PH_DATA;
                            if (!r_copy) begin
                                n_copy = 1'b1;
                            end else begin
                                n_copy = 1'b0;
                                if (r_slot == SLOT_W'(PATCHES_PER_BANK - 1)) begin
                                    n_slot  = '0;
                                    n_phase = PH_PILOT;
                                    if (r_bank == BANK_W'(BANKS - 1)) begin
                                        n_bank     = '0;
                                        n_done     = 1'b1;
                                        n_out.last = 1'b1;
                                    end else begin
                                        n_bank = r_bank + BANK_W'(1);
                                    end
                                end else begin
                                    n_slot = r_slot + SLOT_W'(1);
                                end
                            end
                        end
                    end
                    default: begin
                        n_tone = tone_inc[PILOT_W-1:0];
                        if (tone_inc >= pilot_lim) begin
                            n_tone  = '0;
                            n_phase = PH_DATA;
                            n_slot  = '0;
                            n_copy  = 1'b0;
                            n_byte  = '0;
                            n_fbit  = '0;
                            n_sum   = '0;
                        end
                    end
                endcase
            end
        end
    end

    // Prefetch the byte the next state will need
    always_comb begin
        rd_off  = (int'(n_byte) >= DATA_BYTES) ? '0 : n_byte;
        rd_addr = ADDR_W'((int'(n_bank) * PATCHES_PER_BANK + int'(n_slot)) * DATA_BYTES
                  + int'(rd_off));
    end

    // Write loaded bytes and register the prefetch read
    always_ff @(posedge i_clk) begin
        if (fire && i_q_cmd.wr_en) begin
            r_store[i_q_cmd.wr_addr] <= i_q_cmd.wr_data;
        end
        r_rd_data <= r_store[rd_addr];
    end

    // Hold state and the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_PILOT;
            r_tone  <= '0;
            r_bank  <= '0;
            r_slot  <= '0;
            r_copy  <= 1'b0;
            r_byte  <= '0;
            r_fbit  <= '0;
            r_sum   <= '0;
            r_done  <= 1'b0;
            r_rd_ok <= 1'b0;
            r_ov    <= 1'b0;
            r_out   <= '0;
        end else begin
            r_phase <= n_phase;
            r_tone  <= n_tone;
            r_bank  <= n_bank;
            r_slot  <= n_slot;
            r_copy  <= n_copy;
            r_byte  <= n_byte;
            r_fbit  <= n_fbit;
            r_sum   <= n_sum;
            r_done  <= n_done;
            // a load may write the byte being prefetched, so read again
            r_rd_ok <= !(fire && i_q_cmd.is_load);
            if (fire) begin
                r_ov  <= 1'b1;
                r_out <= n_out;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_ov;
    assign o_out_word  = r_out;

endmodule

>>> bench/tb_tape_patch_bit_serializer_unit.sv
`timescale 1ns / 1ps

module tb_tape_patch_bit_serializer_unit;
    import tpbs_pkg::*;

    localparam logic [2:0] ADDR_PILOT  = {REG_PILOT, 2'b00};
    localparam logic [2:0] ADDR_SEP    = {REG_SEP, 2'b00};
    localparam int         QUIET_LIMIT = 2000;
    localparam int         SETTLE      = 8;
    localparam int         SHOW_MAX    = 10;

    typedef enum logic [1:0] {
        TAPE_PILOT = 2'd0,
        TAPE_DATA  = 2'd1,
        TAPE_SEP   = 2'd2
    } t_tape_phase;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    t_in_word    i_in_word;
    logic        o_out_valid;
    logic        i_out_ready;
    t_out_word   o_out_word;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // Tape image and sequencer state as the host expects it
    logic [7:0]         patch_mem [STORE_SIZE];
    t_tape_phase        tape_phase;
    logic [PILOT_W-1:0] tone_cnt;
    logic [BANK_W-1:0]  bank_cnt;
    logic [SLOT_W-1:0]  slot_cnt;
    logic               copy_cnt;
    logic [BYTE_W-1:0]  byte_cnt;
    logic [FBIT_W-1:0]  frame_cnt;
    logic [7:0]         patch_sum;
    logic               tape_done;
    logic [PILOT_W-1:0] pilot_len;
    logic [SEP_W-1:0]   sep_len;

    t_out_word   pending_bits [$];
    int unsigned mismatch_count;
    int unsigned line_words;
    int unsigned quiet_cycles;
    int unsigned stall_left;
    bit          src_gaps_on;
    bit          sink_stalls_on;

    tape_patch_bit_serializer_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // Run the clock
    always #5 i_clk = ~i_clk;

    // Pick an idle length: mostly short, now and then long
    function automatic int unsigned gap_len();
        if ($urandom_range(0, 99) < 85) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(4, 30);
    endfunction

    // Rewind the tape to the first pilot bit
    function automatic void rewind_tape();
        tape_phase = TAPE_PILOT;
        tone_cnt   = '0;
        bank_cnt   = '0;
        slot_cnt   = '0;
        copy_cnt   = 1'b0;
        byte_cnt   = '0;
        frame_cnt  = '0;
        patch_sum  = '0;
        tape_done  = 1'b0;
    endfunction

    // Advance the tape by one input word and return the line bit it yields
    function automatic t_out_word advance_tape(t_in_word w);
        t_out_word  r;
        logic [7:0] cur;
        int         pilot_end;
        int         sep_end;
        pilot_end   = (pilot_len == '0) ? 1 : int'(pilot_len);
        sep_end     = (sep_len == '0) ? 1 : int'(sep_len);
        r.line_bit  = 1'b1;
        r.bit_valid = 1'b0;
        r.last      = 1'b0;
        if (w.op == OP_LOAD) begin
            if (int'(w.bank) < BANKS && int'(w.slot) < PATCHES_PER_BANK &&
                int'(w.byte_index) < DATA_BYTES) begin
                patch_mem[(int'(w.bank) * PATCHES_PER_BANK + int'(w.slot)) * DATA_BYTES
                          + int'(w.byte_index)] = w.data;
            end
            rewind_tape();
        end else if (!tape_done) begin
            r.bit_valid = 1'b1;
            case (tape_phase)
                TAPE_DATA: begin
                    // Data bytes first, then the checksum byte
                    if (int'(byte_cnt) >= DATA_BYTES) begin
                        cur = patch_sum;
                    end else begin
                        cur = patch_mem[(int'(bank_cnt) * PATCHES_PER_BANK + int'(slot_cnt))
                                        * DATA_BYTES + int'(byte_cnt)];
                    end
                    if (frame_cnt == '0) begin
                        r.line_bit = 1'b0;
                    end else if (frame_cnt <= 4'd8) begin
                        r.line_bit = cur[3'(frame_cnt - 4'd1)];
                    end else begin
                        r.line_bit = 1'b1;
                    end
                    frame_cnt = frame_cnt + 4'd1;
                    if (int'(frame_cnt) >= FRAME_BITS) begin
                        frame_cnt = '0;
                        if (int'(byte_cnt) < DATA_BYTES) begin
                            patch_sum = patch_sum + cur;
                        end
                        if (int'(byte_cnt) == RAW_BYTES - 1) begin
                            byte_cnt   = '0;
                            tape_phase = TAPE_SEP;
                            tone_cnt   = '0;
                        end else begin
                            byte_cnt = byte_cnt + BYTE_W'(1);
                        end
                    end
                end
                TAPE_SEP: begin
                    tone_cnt = tone_cnt + PILOT_W'(1);
                    if (int'(tone_cnt) >= sep_end) begin
                        tone_cnt   = '0;
                        patch_sum  = '0;
                        byte_cnt   = '0;
                        frame_cnt  = '0;
                        tape_phase = TAPE_DATA;
                        if (!copy_cnt) begin
                            copy_cnt = 1'b1;
                        end else begin
                            copy_cnt = 1'b0;
                            if (int'(slot_cnt) == PATCHES_PER_BANK - 1) begin
                                slot_cnt   = '0;
                                tape_phase = TAPE_PILOT;
                                if (int'(bank_cnt) == BANKS - 1) begin
                                    bank_cnt  = '0;
                                    tape_done = 1'b1;
                                    r.last    = 1'b1;
                                end else begin
                                    bank_cnt = bank_cnt + BANK_W'(1);
                                end
                            end else begin
                                slot_cnt = slot_cnt + SLOT_W'(1);
                            end
                        end
                    end
                end
                default: begin
                    // Pilot tone; an unused phase code behaves the same
                    tone_cnt = tone_cnt + PILOT_W'(1);
                    if (int'(tone_cnt) >= pilot_end) begin
                        tone_cnt   = '0;
                        tape_phase = TAPE_DATA;
                        slot_cnt   = '0;
                        copy_cnt   = 1'b0;
                        byte_cnt   = '0;
                        frame_cnt  = '0;
                        patch_sum  = '0;
                    end
                end
            endcase
        end
        return r;
    endfunction

    function automatic t_in_word tick_word();
        t_in_word w;
        w.op         = OP_TICK;
        w.bank       = 1'($urandom_range(0, 1));
        w.slot       = 4'($urandom_range(0, 15));
        w.byte_index = 5'($urandom_range(0, 31));
        w.data       = 8'($urandom_range(0, 255));
        return w;
    endfunction

    function automatic t_in_word load_word(int bank, int slot, int idx, int data);
        t_in_word w;
        w.op         = OP_LOAD;
        w.bank       = 1'(bank);
        w.slot       = 4'(slot);
        w.byte_index = 5'(idx);
        w.data       = 8'(data);
        return w;
    endfunction

    // Send one word, hold it until taken, then log the bit it should yield
    task automatic send_word(input t_in_word w);
        int unsigned gap;
        gap = (src_gaps_on && $urandom_range(0, 99) < 30) ? gap_len() : 0;
        @(negedge i_clk);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        pending_bits.push_back(advance_tape(w));
    endtask

    task automatic send_ticks(input int unsigned count);
        repeat (count) send_word(tick_word());
    endtask

    // Drop valid and wait until every line bit is back
    task automatic drain_line();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_bits.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (addr == ADDR_PILOT) begin
            pilot_len = value[PILOT_W-1:0];
        end else if (addr == ADDR_SEP) begin
            sep_len = value[SEP_W-1:0];
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_tones(input int pilot, input int sep);
        drain_line();
        write_reg(ADDR_PILOT, 32'(pilot));
        write_reg(ADDR_SEP, 32'(sep));
    endtask

    task automatic flag_error(input string msg);
        mismatch_count++;
        if (mismatch_count <= SHOW_MAX) begin
            $display("%s", msg);
        end
    endtask

    // Compare each taken line bit with the oldest prediction
    always @(posedge i_clk) begin : check_line
        t_out_word want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_bits.size() == 0) begin
                flag_error($sformatf("line word %0d: unexpected, got bit=%0b valid=%0b last=%0b",
                                     line_words, o_out_word.line_bit,
                                     o_out_word.bit_valid, o_out_word.last));
            end else begin
                want = pending_bits.pop_front();
                if (o_out_word.line_bit !== want.line_bit ||
                    o_out_word.bit_valid !== want.bit_valid ||
                    o_out_word.last !== want.last) begin
                    flag_error($sformatf(
                        "line word %0d: expected bit=%0b valid=%0b last=%0b, got %0b/%0b/%0b",
                        line_words, want.line_bit, want.bit_valid, want.last,
                        o_out_word.line_bit, o_out_word.bit_valid, o_out_word.last));
                end
            end
            line_words++;
        end
    end

    // Stall the result side at random
    always @(negedge i_clk) begin
        if (stall_left != 0) begin
            stall_left  <= stall_left - 1;
            i_out_ready <= 1'b0;
        end else if (sink_stalls_on && $urandom_range(0, 99) < 20) begin
            stall_left  <= gap_len() - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Abort when nothing moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles + 1 >= QUIET_LIMIT) begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // Reset values give a long pilot; stay well inside it
    task automatic test_reset_tone();
        send_ticks(24);
        drain_line();
    endtask

    // Load the first patch
    task automatic test_fill_store();
        int data;
        for (int i = 0; i < DATA_BYTES; i++) begin
            data = $urandom_range(0, 255);
            if (i == 1) data = 8'h00;
            if (i == 2) data = 8'hFF;
            send_word(load_word(0, 0, i, data));
        end
        drain_line();
    endtask

    // Field extremes, and a load past the patch end that only restarts
    task automatic test_edge_loads();
        set_tones(1, 2);
        send_word(load_word(BANKS - 1, PATCHES_PER_BANK - 1, DATA_BYTES - 1, 8'hFF));
        send_word(load_word(0, 0, 0, 8'h00));
        send_word(load_word(0, 0, 31, 8'h5A));
        send_ticks(1 + 2 * FRAME_BITS);
        drain_line();
    endtask

    // Zero pilot length acts as one bit
    task automatic test_zero_tones();
        set_tones(0, 0);
        send_word(load_word(1, 3, 7, $urandom_range(0, 255)));
        send_ticks(1 + 2 * FRAME_BITS);
        drain_line();
    endtask

    // Shorten a tone already past its new length: it ends on the next tick;
    // a zero separator acts as one bit
    task automatic test_tone_change();
        set_tones(4096, 48);
        send_word(load_word(0, 5, 5, $urandom_range(0, 255)));
        send_ticks(40);
        drain_line();
        write_reg(ADDR_PILOT, 32'd5);
        send_ticks(1 + RAW_BYTES * FRAME_BITS + 10);
        drain_line();
        write_reg(ADDR_SEP, 32'd0);
        send_ticks(20);
        drain_line();
    endtask

    // Restart, then mostly ticks with a sprinkle of loads, over several settings
    task automatic test_random_traffic();
        int pilot;
        int sep;
        for (int round = 0; round < 4; round++) begin
            pilot = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 300) : $urandom_range(0, 6);
            sep   = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 300) : $urandom_range(0, 6);
            set_tones(pilot, sep);
            src_gaps_on    = $urandom_range(0, 3) != 0;
            sink_stalls_on = $urandom_range(0, 3) != 0;
            send_word(load_word($urandom_range(0, 1), $urandom_range(0, 15),
                                $urandom_range(0, 31), $urandom_range(0, 255)));
            for (int n = 0; n < 29; n++) begin
                if (round == 0 && n == 14) drain_line();
                if ($urandom_range(0, 99) < 3) begin
                    send_word(load_word($urandom_range(0, 1), $urandom_range(0, 15),
                                        $urandom_range(0, 31), $urandom_range(0, 255)));
                end else begin
                    send_word(tick_word());
                end
            end
        end
        src_gaps_on    = 1'b1;
        sink_stalls_on = 1'b1;
        drain_line();
    endtask

    initial begin
        i_clk          = 1'b0;
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_in_word      = '0;
        i_out_ready    = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        mismatch_count = 0;
        line_words     = 0;
        quiet_cycles   = 0;
        stall_left     = 0;
        src_gaps_on    = 1'b1;
        sink_stalls_on = 1'b1;
        pilot_len      = PILOT_RESET;
        sep_len        = SEP_RESET;
        rewind_tape();

        // Hold reset, then release on a falling edge
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_tone();
        test_fill_store();
        test_edge_loads();
        test_zero_tones();
        test_tone_change();
        test_random_traffic();

        drain_line();
        if (mismatch_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
